@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL of this project.
// Included by modules that check their own pipeline behavior; depends on nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, cancelled while the asynchronous reset is asserted.
`define ASSERT_CLKD(label, clock, rstn, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!(rstn)) prop) else $error(msg);
// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
	label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define ASSERT_CLKD(label, clock, rstn, prop, msg)
`define ASSERT_ALWAYS(label, clock, prop, msg)
`endif
`endif

@@ rtl/core/ssmd_pkg.sv @@
// Package for the signed scaled multiply-divide block: widths, pipeline depth, types.
// Depends on nothing; used by signed_scaled_multiply_divide.
package ssmd_pkg;

	localparam int CELL_BITS       = 32;
	localparam int DBITS           = 2 * CELL_BITS;
	localparam int TRI_BITS        = 3 * CELL_BITS;
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = (TRI_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	// Absolute value, product, product sum, divider stages, output register.
	localparam int LATENCY         = 3 + DIV_STAGES + 1;

	typedef struct packed {
		logic dbz;      // divisor was zero
		logic neg;      // operand signs differ
		logic both_nz;  // dividend and multiplier both nonzero
	} ssmd_flags_t;

endpackage

@@ rtl/core/signed_scaled_multiply_divide.sv @@
// Top level of the signed scaled multiply-divide block (double * single / single).
// Depends on ssmd_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Signed scaled multiply-divide. Each beat taken on start carries a signed double-cell
// dividend, a signed single-cell multiplier and an unsigned single-cell divisor. The
// block multiplies the magnitudes into a triple-cell product, divides it by the divisor
// with truncation, keeps the low double cell of the quotient, clears its top bit and
// negates it when the operand signs differ (a negative result that truncates to zero
// while both operands are nonzero comes out as the most negative double value). A zero
// divisor gives a zero quotient with divide_by_zero set.
// Rate: a new beat is taken in every cycle; busy is never raised. Each result appears
// on quotient and divide_by_zero with done high for exactly one cycle, in the order
// the beats went in. The receiver cannot hold results off, and none is needed since
// the pipeline never stalls. The pipeline holds three front stages (magnitudes, two
// single-by-single partial products, their sum), the restoring divider, which retires
// four quotient bits per stage over the whole triple-cell product, and the output register.
module signed_scaled_multiply_divide (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [ssmd_pkg::DBITS-1:0]     dividend,
	input  logic signed [ssmd_pkg::CELL_BITS-1:0] multiplier,
	input  logic        [ssmd_pkg::CELL_BITS-1:0] divisor,
	output logic                               done,
	output logic signed [ssmd_pkg::DBITS-1:0]     quotient,
	output logic                               divide_by_zero
);
	import ssmd_pkg::*;

	// Stage 1: magnitudes and flags.
	logic                 vld_s1;
	logic [DBITS-1:0]     mag_u_s1;
	logic [CELL_BITS-1:0] mag_n_s1;
	logic [CELL_BITS-1:0] div_s1;
	ssmd_flags_t          flg_s1;

	// Stage 2: two single-by-single partial products.
	logic                 vld_s2;
	logic [DBITS-1:0]     prod_lo_s2;
	logic [DBITS-1:0]     prod_hi_s2;
	logic [CELL_BITS-1:0] div_s2;
	ssmd_flags_t          flg_s2;

	// Divider pipeline; entry 0 is loaded with the summed product (stage 3).
	logic                 div_vld_s  [0:DIV_STAGES];
	logic [CELL_BITS-1:0] div_rem_s  [0:DIV_STAGES];
	logic [TRI_BITS-1:0]  div_work_s [0:DIV_STAGES];
	logic [CELL_BITS-1:0] div_d_s    [0:DIV_STAGES];
	ssmd_flags_t          div_flg_s  [0:DIV_STAGES];

	// Output register.
	logic                 done_q;
	logic [DBITS-1:0]     quot_q;
	logic                 dbz_q;

	logic                 sgn_u;
	logic                 sgn_n;
	logic [DBITS-1:0]     q_clr;
	logic [DBITS-1:0]     q_fin;

	// The pipeline never stalls and results cannot be held off.
	assign busy = 1'b0;

	assign sgn_u = dividend[DBITS-1];
	assign sgn_n = multiplier[CELL_BITS-1];

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int i = 0; i <= DIV_STAGES; i++) begin
				div_vld_s[i] <= 1'b0;
			end
			done_q <= 1'b0;
		end else begin
			vld_s1       <= start;
			vld_s2       <= vld_s1;
			div_vld_s[0] <= vld_s2;
			for (int i = 1; i <= DIV_STAGES; i++) begin
				div_vld_s[i] <= div_vld_s[i-1];
			end
			done_q <= div_vld_s[DIV_STAGES];
		end
	end

	// Stage 1: the most negative operand becomes 2^(width-1) as an unsigned magnitude.
	always_ff @(posedge clk) begin
		mag_u_s1       <= sgn_u ? (~dividend + 1'b1) : dividend;
		mag_n_s1       <= sgn_n ? (~multiplier + 1'b1) : multiplier;
		div_s1         <= divisor;
		flg_s1.dbz     <= (divisor == '0);
		flg_s1.neg     <= sgn_u ^ sgn_n;
		flg_s1.both_nz <= (dividend != '0) && (multiplier != '0);
	end

	// Stage 2: split the double-cell magnitude into cells, one multiply per cell.
	always_ff @(posedge clk) begin
		prod_lo_s2 <= DBITS'(mag_u_s1[CELL_BITS-1:0]) * DBITS'(mag_n_s1);
		prod_hi_s2 <= DBITS'(mag_u_s1[DBITS-1:CELL_BITS]) * DBITS'(mag_n_s1);
		div_s2     <= div_s1;
		flg_s2     <= flg_s1;
	end

	// Stage 3: sum the partial products into the triple-cell dividend of the divider.
	always_ff @(posedge clk) begin
		div_work_s[0] <= {prod_hi_s2, {CELL_BITS{1'b0}}} + TRI_BITS'(prod_lo_s2);
		div_rem_s[0]  <= '0;
		div_d_s[0]    <= div_s2;
		div_flg_s[0]  <= flg_s2;
	end

	// Restoring divider. The work word shifts product bits out at the top and
	// quotient bits in at the bottom; the partial remainder always stays below
	// the divisor, so one compare and subtract settles each bit.
	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
		logic [CELL_BITS-1:0] rem_v;
		logic [TRI_BITS-1:0]  work_v;
		logic [CELL_BITS:0]   trial;

		always_comb begin
			rem_v  = div_rem_s[g];
			work_v = div_work_s[g];
			trial  = '0;
			for (int k = 0; k < STEPS_PER_STAGE; k++) begin
				if (g * STEPS_PER_STAGE + k < TRI_BITS) begin
					trial  = {rem_v, work_v[TRI_BITS-1]};
					work_v = {work_v[TRI_BITS-2:0], 1'b0};
					if (trial >= {1'b0, div_d_s[g]}) begin
						trial     = trial - {1'b0, div_d_s[g]};
						work_v[0] = 1'b1;
					end
					rem_v = trial[CELL_BITS-1:0];
				end
			end
		end

		always_ff @(posedge clk) begin
			div_rem_s[g+1]  <= rem_v;
			div_work_s[g+1] <= work_v;
			div_d_s[g+1]    <= div_d_s[g];
			div_flg_s[g+1]  <= div_flg_s[g];
		end
	end

	// Final stage: keep the low double cell, clear its top bit, then apply the sign.
	always_comb begin
		q_clr = {1'b0, div_work_s[DIV_STAGES][DBITS-2:0]};
		if (div_flg_s[DIV_STAGES].dbz) begin
			q_fin = '0;
		end else if (div_flg_s[DIV_STAGES].neg) begin
			if (q_clr == '0 && div_flg_s[DIV_STAGES].both_nz) begin
				q_fin = {1'b1, {(DBITS-1){1'b0}}};
			end else begin
				q_fin = ~q_clr + 1'b1;
			end
		end else begin
			q_fin = q_clr;
		end
	end

	always_ff @(posedge clk) begin
		quot_q <= q_fin;
		dbz_q  <= div_flg_s[DIV_STAGES].dbz;
	end

	assign done           = done_q;
	assign quotient       = quot_q;
	assign divide_by_zero = dbz_q;

	`ASSERT_CLKD(a_start_gives_done, clk, arst_n, start |-> ##LATENCY done, "beat taken on start did not come out after the pipeline latency")
	`ASSERT_CLKD(a_zero_div_flagged, clk, arst_n, (start && divisor == '0) |-> ##LATENCY (done && divide_by_zero), "zero divisor not flagged on its result")
	`ASSERT_CLKD(a_nonzero_div_clear, clk, arst_n, (start && divisor != '0) |-> ##LATENCY (done && !divide_by_zero), "nonzero divisor flagged as zero divide")
	`ASSERT_CLKD(a_dbz_zero_quot, clk, arst_n, (done && divide_by_zero) |-> (quotient == '0), "zero-divide result carries a nonzero quotient")
	`ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised on a pipeline that never stalls")

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for signed_scaled_multiply_divide (double * single / single).
// Depends on ssmd_pkg and the RTL top level; needs no files or arguments at run time.

module testbench;
	import ssmd_pkg::*;

	// Give up once this many cycles pass with no beat taken and no result seen. This is
	// several times the slowest correct gap: reset, the longest sender pause and one
	// full trip through the pipeline.
	localparam int WATCHDOG_LIMIT = 8 * (LATENCY + 6 + 12);
	localparam int N_RANDOM       = 1000;
	localparam int QUIET_TAIL     = 150;
	localparam int N_DIRECTED     = 23;
	localparam int PRINT_CAP      = 50;

	// One expected result: the scaled quotient and the zero-divisor flag.
	typedef struct packed {
		logic [DBITS-1:0] q;
		logic             dbz;
	} scaled_result_t;

	// One directed beat. Where fixed is set, the expected result is written out in the
	// row; otherwise the predictor works it out when the beat is taken.
	typedef struct packed {
		logic [DBITS-1:0]     dvd;
		logic [CELL_BITS-1:0] mul;
		logic [CELL_BITS-1:0] dvs;
		bit                   fixed;
		logic [DBITS-1:0]     q;
		bit                   dbz;
	} stim_row_t;

	localparam logic [DBITS-1:0] D_MIN = {1'b1, {(DBITS-1){1'b0}}};
	localparam logic [DBITS-1:0] D_MAX = {1'b0, {(DBITS-1){1'b1}}};

	logic                        clk            = 1'b0;
	logic                        arst_n         = 1'b0;
	logic                        start          = 1'b0;
	logic                        busy;
	logic signed [DBITS-1:0]     dividend       = '0;
	logic signed [CELL_BITS-1:0] multiplier     = '0;
	logic        [CELL_BITS-1:0] divisor        = '0;
	logic                        done;
	logic signed [DBITS-1:0]     quotient;
	logic                        divide_by_zero;

	// The written-out expectation travels with the beat it belongs to, so the monitor
	// sees it at the same edge that takes the beat.
	bit                          beat_fixed     = 1'b0;
	logic        [DBITS-1:0]     beat_quotient  = '0;
	bit                          beat_dbz       = 1'b0;

	scaled_result_t              pending_results[$];
	int                          mismatch_count = 0;
	int                          stall_cycles   = 0;

	// Directed beats: zero divisor, zero operands, the most negative and most positive
	// values of every field, negative results that truncate to zero, quotients that
	// spill past the double cell, and a few plain mixed-sign cases.
	stim_row_t directed_rows [N_DIRECTED] = '{
		'{64'h0, 32'h0, 32'h0, 1'b1, 64'h0, 1'b1},
		'{D_MAX, 32'h8000_0000, 32'h0, 1'b1, 64'h0, 1'b1},
		'{64'h0, 32'h5, 32'h7, 1'b1, 64'h0, 1'b0},
		'{64'h0, 32'hFFFF_FFFB, 32'h7, 1'b1, 64'h0, 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFFB, 32'h0, 32'h7, 1'b1, 64'h0, 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFFF, 32'h1, 32'h2, 1'b1, D_MIN, 1'b0},
		'{64'h1, 32'hFFFF_FFFF, 32'h1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
		'{64'h7, 32'h3, 32'h2, 1'b1, 64'd10, 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFF9, 32'h3, 32'h2, 1'b1, 64'hFFFF_FFFF_FFFF_FFF6, 1'b0},
		'{64'hFFFF_FFFF_FFFF_FFF9, 32'hFFFF_FFFD, 32'h2, 1'b1, 64'd10, 1'b0},
		'{D_MIN, 32'h1, 32'h1, 1'b1, D_MIN, 1'b0},
		'{D_MIN, 32'hFFFF_FFFF, 32'h1, 1'b1, 64'h0, 1'b0},
		'{D_MAX, 32'h1, 32'h1, 1'b1, D_MAX, 1'b0},
		'{64'h1, 32'h8000_0000, 32'h1, 1'b1, 64'hFFFF_FFFF_8000_0000, 1'b0},
		'{64'd100, 32'h1, 32'hFFFF_FFFF, 1'b1, 64'h0, 1'b0},
		'{64'hFFFF_FFFF_FFFF_FF9C, 32'h1, 32'hFFFF_FFFF, 1'b1, D_MIN, 1'b0},
		'{64'h4000_0000_0000_0000, 32'h4, 32'h1, 1'b1, 64'h0, 1'b0},
		'{64'hC000_0000_0000_0000, 32'h4, 32'h1, 1'b1, D_MIN, 1'b0},
		'{D_MAX, 32'h7FFF_FFFF, 32'h1, 1'b0, 64'h0, 1'b0},
		'{D_MIN, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 64'h0, 1'b0},
		'{D_MAX, 32'h8000_0000, 32'h3, 1'b0, 64'h0, 1'b0},
		'{64'h0123_4567_89AB_CDEF, 32'h1234_5678, 32'h0000_1000, 1'b0, 64'h0, 1'b0},
		'{64'hFEDC_BA98_7654_3210, 32'h7654_3210, 32'hFFFF_FFFE, 1'b0, 64'h0, 1'b0}
	};

	signed_scaled_multiply_divide u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.dividend       (dividend),
		.multiplier     (multiplier),
		.divisor        (divisor),
		.done           (done),
		.quotient       (quotient),
		.divide_by_zero (divide_by_zero)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Scaled quotient of one beat: magnitudes multiplied into a triple cell, divided with
	// truncation, cut to the double cell, top bit cleared, then signed. A negative result
	// that truncates to zero from two nonzero operands becomes the most negative value.
	function automatic scaled_result_t scale_quotient(logic [DBITS-1:0] dvd,
			logic [CELL_BITS-1:0] mul, logic [CELL_BITS-1:0] dvs);
		scaled_result_t       r;
		logic                 neg_d;
		logic                 neg_m;
		logic [DBITS-1:0]     mag_d;
		logic [CELL_BITS-1:0] mag_m;
		logic [TRI_BITS-1:0]  product;
		logic [TRI_BITS-1:0]  full_q;
		logic [DBITS-1:0]     q;
		r.q   = '0;
		r.dbz = 1'b1;
		if (dvs == '0)
			return r;
		neg_d   = dvd[DBITS-1];
		neg_m   = mul[CELL_BITS-1];
		mag_d   = neg_d ? -dvd : dvd;
		mag_m   = neg_m ? -mul : mul;
		product = TRI_BITS'(mag_d) * TRI_BITS'(mag_m);
		full_q  = product / TRI_BITS'(dvs);
		q       = full_q[DBITS-1:0];
		q[DBITS-1] = 1'b0;
		if (neg_d != neg_m) begin
			if (q == '0 && mag_d != '0 && mag_m != '0)
				q = D_MIN;
			else
				q = -q;
		end
		r.q   = q;
		r.dbz = 1'b0;
		return r;
	endfunction

	// A signed operand of the given width: full random most of the time, otherwise a
	// small value or a power of two, each possibly negated, or one of the extremes.
	function automatic logic [DBITS-1:0] pick_operand(int unsigned width);
		logic [DBITS-1:0] v;
		logic [DBITS-1:0] mask;
		mask = (width == DBITS) ? '1 : ((DBITS'(1) << width) - 1);
		v    = DBITS'({$urandom(), $urandom()});
		case ($urandom_range(0, 7))
			1: begin
				v = DBITS'($urandom_range(0, 300));
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			2: begin
				case ($urandom_range(0, 4))
					0: v = DBITS'(1) << (width - 1);
					1: v = (DBITS'(1) << (width - 1)) - 1;
					2: v = '0;
					3: v = '1;
					default: v = DBITS'(1);
				endcase
			end
			3: begin
				v = DBITS'(1) << $urandom_range(0, width - 1);
				if ($urandom_range(0, 1) == 1)
					v = -v;
			end
			default: ;
		endcase
		return v & mask;
	endfunction

	function automatic logic [CELL_BITS-1:0] pick_divisor();
		logic [CELL_BITS-1:0] v;
		v = CELL_BITS'($urandom());
		case ($urandom_range(0, 15))
			0: v = '0;
			1: v = CELL_BITS'(1);
			2, 3: v = CELL_BITS'($urandom_range(1, 300));
			4: v = '1;
			5: v = CELL_BITS'(1) << $urandom_range(0, CELL_BITS - 1);
			default: ;
		endcase
		return v;
	endfunction

	task automatic report_mismatch(string what, logic [DBITS-1:0] got,
			logic [DBITS-1:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Present one beat and hold it until the block takes it. Called at a rising edge;
	// returns at the edge that took the beat.
	task automatic drive_beat(logic [DBITS-1:0] dvd, logic [CELL_BITS-1:0] mul,
			logic [CELL_BITS-1:0] dvs, bit fixed, logic [DBITS-1:0] q, bit dbz);
		start         <= 1'b1;
		dividend      <= dvd;
		multiplier    <= mul;
		divisor       <= dvs;
		beat_fixed    <= fixed;
		beat_quotient <= q;
		beat_dbz      <= dbz;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Sender. Directed rows first, then random beats. Pauses of random length come before
	// some random beats, but some stretches and the tail of the run go back to back.
	initial begin
		int  pause_len;
		bit  pauses_on;
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);
		foreach (directed_rows[i])
			drive_beat(directed_rows[i].dvd, directed_rows[i].mul, directed_rows[i].dvs,
				directed_rows[i].fixed, directed_rows[i].q, directed_rows[i].dbz);
		for (int i = 0; i < N_RANDOM; i++) begin
			pauses_on = (i < N_RANDOM - QUIET_TAIL) && ((i / 100) % 3 != 2);
			if (pauses_on && $urandom_range(0, 3) == 0) begin
				pause_len = $urandom_range(1, 6);
				start <= 1'b0;
				repeat (pause_len) @(posedge clk);
			end
			drive_beat(pick_operand(DBITS), CELL_BITS'(pick_operand(CELL_BITS)),
				pick_divisor(), 1'b0, '0, 1'b0);
		end
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		// Anything that shows up now had no beat behind it.
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	// Monitor. A result is checked against the oldest expectation before this edge's beat
	// is queued; with a pipeline this deep the two can never be the same item.
	always @(posedge clk) begin
		scaled_result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with no beat pending", quotient, '0);
				end else begin
					want = pending_results.pop_front();
					if (quotient !== want.q)
						report_mismatch("quotient", quotient, want.q);
					if (divide_by_zero !== want.dbz)
						report_mismatch("divide_by_zero", DBITS'(divide_by_zero),
							DBITS'(want.dbz));
				end
			end
			if (start && !busy) begin
				if (beat_fixed) begin
					want.q   = beat_quotient;
					want.dbz = beat_dbz;
				end else begin
					want = scale_quotient(dividend, multiplier, divisor);
				end
				pending_results.push_back(want);
			end
		end
	end

	// Watchdog: counts edges at which no beat is taken and no result appears.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

endmodule
